FILE: sv/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg: shared types and constants for the sound generator
// Request codes, register indexes, amplitude table and the structs that
// travel between the register file, the voice generator and the mixer.
// ----------------------------------------------------------------------------
package psg_pkg;

  typedef enum logic [1:0] {
    ACT_SELECT = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  localparam int NumVoices = 3;
  localparam int NumRegs   = 16;

  localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
  localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
  localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
  localparam logic [3:0] REG_NOISE         = 4'd6;
  localparam logic [3:0] REG_MIXER         = 4'd7;
  localparam logic [3:0] REG_AMP_A         = 4'd8;
  localparam logic [3:0] REG_AMP_B         = 4'd9;
  localparam logic [3:0] REG_AMP_C         = 4'd10;
  localparam logic [3:0] REG_ENV_FINE      = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
  localparam logic [3:0] REG_SHAPE         = 4'd13;
  localparam logic [3:0] REG_IO_A          = 4'd14;
  localparam logic [3:0] REG_IO_B          = 4'd15;

  localparam logic [23:0] RATIO_RESET = 24'd2660413;
  localparam logic [16:0] SHIFT_SEED  = 17'h00001;

  localparam logic [7:0] AMP_TABLE [16] = '{
    8'd0, 8'd1, 8'd1, 8'd2, 8'd2, 8'd3, 8'd5, 8'd6,
    8'd9, 8'd13, 8'd18, 8'd26, 8'd36, 8'd51, 8'd73, 8'd85
  };

  typedef struct packed {
    logic       sel;
    logic       wr;
    logic       tick;
    logic [7:0] data;
  } psg_op_t;

  typedef struct packed {
    logic [NumVoices-1:0][11:0] tone_period;
    logic [4:0]                 noise_period;
    logic [15:0]                env_period;
    logic [3:0]                 shape;
    logic [7:0]                 mixer;
    logic [NumVoices-1:0][4:0]  amp;
    logic                       env_restart;
    logic                       restart_attack;
  } psg_regs_t;

  typedef struct packed {
    logic [NumVoices-1:0] tone;
    logic                 noise;
    logic [3:0]           env_volume;
  } psg_levels_t;

endpackage

FILE: sv/psg_regfile.sv
// ----------------------------------------------------------------------------
// psg_regfile: register select latch and the sixteen chip registers
// Masks each write to the register's width and flags shape writes.
// ----------------------------------------------------------------------------
module psg_regfile import psg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  psg_op_t   op,
  output psg_regs_t regs,
  output logic [7:0] read_data
);

  logic [3:0] sel;
  logic [7:0] rf [NumRegs];
  logic [7:0] wdata;

  always_comb begin
    case (sel)
      REG_TONE_A_COARSE, REG_TONE_B_COARSE, REG_TONE_C_COARSE, REG_SHAPE: begin
        wdata = {4'b0, op.data[3:0]};
      end
      REG_NOISE, REG_AMP_A, REG_AMP_B, REG_AMP_C: begin
        wdata = {3'b0, op.data[4:0]};
      end
      default: begin
        wdata = op.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
      for (int i = 0; i < NumRegs; i++) begin
        rf[i] <= 8'h00;
      end
      rf[REG_MIXER] <= 8'hFF;
      rf[REG_IO_A]  <= 8'hFF;
      rf[REG_IO_B]  <= 8'hFF;
    end else begin
      if (op.sel) begin
        sel <= op.data[3:0];
      end
      if (op.wr) begin
        rf[sel] <= wdata;
      end
    end
  end

  always_comb begin
    regs.tone_period[0] = {rf[REG_TONE_A_COARSE][3:0], rf[REG_TONE_A_FINE]};
    regs.tone_period[1] = {rf[REG_TONE_B_COARSE][3:0], rf[REG_TONE_B_FINE]};
    regs.tone_period[2] = {rf[REG_TONE_C_COARSE][3:0], rf[REG_TONE_C_FINE]};
    regs.noise_period   = rf[REG_NOISE][4:0];
    regs.env_period     = {rf[REG_ENV_COARSE], rf[REG_ENV_FINE]};
    regs.shape          = rf[REG_SHAPE][3:0];
    regs.mixer          = rf[REG_MIXER];
    regs.amp[0]         = rf[REG_AMP_A][4:0];
    regs.amp[1]         = rf[REG_AMP_B][4:0];
    regs.amp[2]         = rf[REG_AMP_C][4:0];
    regs.env_restart    = op.wr && (sel == REG_SHAPE);
    regs.restart_attack = op.data[2];
  end

  assign read_data = rf[sel];

endmodule

FILE: sv/psg_gen.sv
// ----------------------------------------------------------------------------
// psg_gen: tone, noise and envelope generators
// Q20 accumulators advance by the clock ratio each tick (not zero-period tones);
// at most one period is taken off per tick. Outputs the levels after this tick.
// ----------------------------------------------------------------------------
module psg_gen import psg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [23:0] ratio,
  input  psg_regs_t   regs,
  output psg_levels_t levels
);

  logic [31:0]          tone_acc [NumVoices];
  logic [31:0]          tone_acc_next [NumVoices];
  logic [NumVoices-1:0] tone_lvl, tone_lvl_next;
  logic [32:0]          tone_sum [NumVoices];
  logic [32:0]          tone_thr [NumVoices];

  logic [31:0] noise_acc, noise_acc_next;
  logic [32:0] noise_sum, noise_thr;
  logic [4:0]  noise_per;
  logic [16:0] noise_shift, noise_shift_next, shift_cur;
  logic        noise_lvl, noise_lvl_next, noise_fb;

  logic [39:0] env_acc, env_acc_next, env_sum, env_thr;
  logic [15:0] env_per;
  logic [3:0]  env_step, env_step_next;
  logic        env_odd, env_odd_next;
  logic        env_past, env_past_next;
  logic [3:0]  env_vol, env_vol_next;
  logic        env_hit;

  function automatic logic [3:0] env_volume(logic [3:0] shape, logic [3:0] step,
                                            logic odd, logic past);
    logic [3:0] ramp;
    logic [3:0] vol;
    ramp = shape[2] ? step : ~step;
    if (!shape[3]) begin
      vol = past ? 4'd0 : ramp;
    end else if (shape[0]) begin
      vol = past ? ((shape[2] != shape[1]) ? 4'd15 : 4'd0) : ramp;
    end else if (!shape[1]) begin
      vol = ramp;
    end else begin
      vol = (shape[2] != odd) ? step : ~step;
    end
    return vol;
  endfunction

  // tone voices: a zero period freezes the voice
  always_comb begin
    for (int v = 0; v < NumVoices; v++) begin
      tone_sum[v] = {1'b0, tone_acc[v]} + {9'b0, ratio};
      tone_thr[v] = {1'b0, regs.tone_period[v], 20'b0};
      tone_acc_next[v] = tone_acc[v];
      tone_lvl_next[v] = tone_lvl[v];
      if (regs.tone_period[v] != '0) begin
        if (tone_sum[v] >= tone_thr[v]) begin
          tone_acc_next[v] = 32'(tone_sum[v] - tone_thr[v]);
          tone_lvl_next[v] = ~tone_lvl[v];
        end else begin
          tone_acc_next[v] = tone_sum[v][31:0];
        end
      end
    end
  end

  // noise: clock the LFSR once per period
  always_comb begin
    noise_per = (regs.noise_period == '0) ? 5'd1 : regs.noise_period;
    noise_sum = {1'b0, noise_acc} + {9'b0, ratio};
    noise_thr = {8'b0, noise_per, 20'b0};
    shift_cur = (noise_shift == '0) ? SHIFT_SEED : noise_shift;
    noise_fb  = shift_cur[0] ^ shift_cur[3];
    noise_acc_next   = noise_sum[31:0];
    noise_shift_next = noise_shift;
    noise_lvl_next   = noise_lvl;
    if (noise_sum >= noise_thr) begin
      noise_acc_next   = 32'(noise_sum - noise_thr);
      noise_shift_next = {noise_fb, shift_cur[16:1]};
      noise_lvl_next   = noise_fb;
    end
  end

  // envelope: step on each period, wrap flips parity and marks the first ramp done
  always_comb begin
    env_per = (regs.env_period == '0) ? 16'd1 : regs.env_period;
    env_sum = env_acc + {16'b0, ratio};
    env_thr = {4'b0, env_per, 20'b0};
    env_hit = (env_sum >= env_thr);
    env_acc_next  = env_sum;
    env_step_next = env_step;
    env_odd_next  = env_odd;
    env_past_next = env_past;
    env_vol_next  = env_vol;
    if (env_hit) begin
      env_acc_next  = env_sum - env_thr;
      env_step_next = env_step + 4'd1;
      if (env_step == 4'd15) begin
        env_past_next = 1'b1;
        env_odd_next  = ~env_odd;
      end
      env_vol_next = env_volume(regs.shape, env_step_next, env_odd_next, env_past_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < NumVoices; v++) begin
        tone_acc[v] <= '0;
      end
      tone_lvl    <= '0;
      noise_acc   <= '0;
      noise_shift <= SHIFT_SEED;
      noise_lvl   <= 1'b0;
      env_acc     <= '0;
      env_step    <= '0;
      env_odd     <= 1'b0;
      env_past    <= 1'b0;
      env_vol     <= '0;
    end else if (tick) begin
      for (int v = 0; v < NumVoices; v++) begin
        tone_acc[v] <= tone_acc_next[v];
      end
      tone_lvl    <= tone_lvl_next;
      noise_acc   <= noise_acc_next;
      noise_shift <= noise_shift_next;
      noise_lvl   <= noise_lvl_next;
      env_acc     <= env_acc_next;
      env_step    <= env_step_next;
      env_odd     <= env_odd_next;
      env_past    <= env_past_next;
      env_vol     <= env_vol_next;
    end else if (regs.env_restart) begin
      // restart: first ramp from its start point
      env_acc  <= '0;
      env_step <= '0;
      env_odd  <= 1'b0;
      env_past <= 1'b0;
      env_vol  <= regs.restart_attack ? 4'd0 : 4'd15;
    end
  end

  assign levels.tone       = tone_lvl_next;
  assign levels.noise      = noise_lvl_next;
  assign levels.env_volume = env_vol_next;

endmodule

FILE: sv/psg_mixer.sv
// ----------------------------------------------------------------------------
// psg_mixer: channel gating and amplitude mix
// Active-low tone and noise enables gate each voice; the enabled voices
// add through the amplitude table, saturated to eight bits.
// ----------------------------------------------------------------------------
module psg_mixer import psg_pkg::*; (
  input  psg_regs_t   regs,
  input  psg_levels_t levels,
  output logic [7:0]  sample
);

  logic [9:0] sum;
  logic       on;
  logic [3:0] lvl;

  always_comb begin
    sum = '0;
    on  = 1'b0;
    lvl = '0;
    for (int v = 0; v < NumVoices; v++) begin
      on  = (regs.mixer[v] | levels.tone[v]) & (regs.mixer[v + NumVoices] | levels.noise);
      lvl = regs.amp[v][4] ? levels.env_volume : regs.amp[v][3:0];
      if (on) begin
        sum = sum + {2'b0, AMP_TABLE[lvl]};
      end
    end
    sample = (sum > 10'd255) ? 8'hFF : sum[7:0];
  end

endmodule

FILE: sv/psg_sound_generator.sv
// ----------------------------------------------------------------------------
// psg_sound_generator: three-voice programmable sound generator
// Request register, single-pass update of registers and generators, and a
// result register that answers reads and delivers mixed samples.
// ----------------------------------------------------------------------------
// An accepted request waits in the request register; the result register
// loads from it once the output is free to advance. Throughput: one request
// per cycle unless the output stalls; a waiting result still lets one more
// request into the request register before the input stalls. The 40-bit
// envelope add and compare, followed by the mix, sets the cycle time.
// Reset clears the pipeline, the generators and the registers to their
// power-up values; the clock ratio returns to its default.
module psg_sound_generator import psg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        read_valid,
  output logic [7:0]  read_data,
  output logic        sample_valid,
  output logic [7:0]  sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  logic [23:0] ratio;
  logic        s_valid;
  action_t     s_action;
  logic [7:0]  s_data;
  logic        advance, fire;
  psg_op_t     op;
  psg_regs_t   regs;
  psg_levels_t levels;
  logic [7:0]  rf_data, mix;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign fire      = s_valid && advance;
  assign in_ready  = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
    end else if (cfg_valid) begin
      ratio <= cfg_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_action <= action_t'(action);
      s_data   <= data_byte;
    end
  end

  always_comb begin
    op.sel  = fire && (s_action == ACT_SELECT);
    op.wr   = fire && (s_action == ACT_WRITE);
    op.tick = fire && (s_action == ACT_TICK);
    op.data = s_data;
  end

  psg_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .regs      (regs),
    .read_data (rf_data)
  );

  psg_gen u_gen (
    .clk    (clk),
    .rst    (rst),
    .tick   (op.tick),
    .ratio  (ratio),
    .regs   (regs),
    .levels (levels)
  );

  psg_mixer u_mixer (
    .regs   (regs),
    .levels (levels),
    .sample (mix)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_valid   <= (s_action == ACT_READ);
      read_data    <= (s_action == ACT_READ) ? rf_data : 8'h00;
      sample_valid <= (s_action == ACT_TICK);
      sample       <= (s_action == ACT_TICK) ? mix : 8'h00;
    end
  end

endmodule

FILE: sv/psg_checker.sv
// ----------------------------------------------------------------------------
// psg_checker: port-level checks for the sound generator
// Result hold under stall, exclusive result kinds, zeroed idle fields and
// the pipeline never refusing requests while its output is empty.
// ----------------------------------------------------------------------------
module psg_checker import psg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        read_valid,
  input logic [7:0]  read_data,
  input logic        sample_valid,
  input logic [7:0]  sample
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_valid) && $stable(read_data)
      && $stable(sample_valid) && $stable(sample))
    else $error("result changed while stalled");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && sample_valid))
    else $error("result is both a read and a sample");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_data == 8'h00)
    else $error("read data not zero outside a read");

  a_sample_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> sample == 8'h00)
    else $error("sample not zero outside a tick");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused while output is empty");

endmodule

bind psg_sound_generator psg_checker u_checker (.*);
